/* hw/rtl/euler_rotate_translate_3d_defines.svh */
// Assertion macros shared by the rotation block.
`ifndef EULER_ROTATE_TRANSLATE_3D_DEFINES_SVH
`define EULER_ROTATE_TRANSLATE_3D_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERT3D_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ERT3D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/ert3d_pkg.sv */
package ert3d_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int ANGLE_WIDTH = 16;
   localparam int COEF_WIDTH  = 19;
   localparam int NUM_COEFS   = 9;
   localparam int NUM_SINES   = 6;
   localparam int NUM_REGS    = 6;
   localparam int REG_IDX_WIDTH = 3;
   localparam int MUL_WIDTH   = 32;
   localparam int MAG_WIDTH   = 20;

   localparam int SINE_OPS = 24;
   localparam int PROD_OPS = 15;
   localparam int NUM_OPS  = SINE_OPS + PROD_OPS;
   localparam int OP_WIDTH = 6;

   localparam logic [REG_IDX_WIDTH-1:0] REG_YAW      = 3'd0;
   localparam logic [REG_IDX_WIDTH-1:0] REG_PITCH    = 3'd1;
   localparam logic [REG_IDX_WIDTH-1:0] REG_ROLL     = 3'd2;
   localparam logic [REG_IDX_WIDTH-1:0] REG_OFFSET_X = 3'd3;
   localparam logic [REG_IDX_WIDTH-1:0] REG_OFFSET_Y = 3'd4;
   localparam logic [REG_IDX_WIDTH-1:0] REG_OFFSET_Z = 3'd5;

   // Polynomial constants of the quarter-wave sine, Q30.
   localparam logic signed [MUL_WIDTH-1:0] SINE_A = 32'sd1686629713;
   localparam logic signed [MUL_WIDTH-1:0] SINE_B = 32'sd688904866;
   localparam logic signed [MUL_WIDTH-1:0] SINE_C = 32'sd76016977;

   localparam int ONE_Q17 = 131072;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;

   // Operand sources for the coefficient products.
   localparam logic [3:0] SRC_SY      = 4'd0;
   localparam logic [3:0] SRC_CY      = 4'd1;
   localparam logic [3:0] SRC_SP      = 4'd2;
   localparam logic [3:0] SRC_CP      = 4'd3;
   localparam logic [3:0] SRC_SR      = 4'd4;
   localparam logic [3:0] SRC_CR      = 4'd5;
   localparam logic [3:0] SRC_CYSP    = 4'd6;
   localparam logic [3:0] SRC_SYSP    = 4'd7;
   localparam logic [3:0] SRC_NEG_ONE = 4'd8;

   // Destinations: 0 to 8 are the coefficients in row-major order.
   localparam logic [3:0] DST_CYSP = 4'd9;
   localparam logic [3:0] DST_SYSP = 4'd10;

   localparam logic [1:0] MODE_SET   = 2'd0;
   localparam logic [1:0] MODE_FIRST = 2'd1;
   localparam logic [1:0] MODE_ADD   = 2'd2;
   localparam logic [1:0] MODE_SUB   = 2'd3;

   typedef struct packed {
      logic [3:0] a_sel;
      logic [3:0] b_sel;
      logic [3:0] dest;
      logic [1:0] mode;
   } prod_op_type;

   function automatic prod_op_type prod_op(input logic [3:0] idx);
      prod_op_type op;
      case (idx)
         4'd0:    op = '{SRC_CY,   SRC_SP,      DST_CYSP, MODE_SET};
         4'd1:    op = '{SRC_SY,   SRC_SP,      DST_SYSP, MODE_SET};
         4'd2:    op = '{SRC_CY,   SRC_CP,      4'd0,     MODE_SET};
         4'd3:    op = '{SRC_CYSP, SRC_SR,      4'd1,     MODE_FIRST};
         4'd4:    op = '{SRC_SY,   SRC_CR,      4'd1,     MODE_SUB};
         4'd5:    op = '{SRC_CYSP, SRC_CR,      4'd2,     MODE_FIRST};
         4'd6:    op = '{SRC_SY,   SRC_SR,      4'd2,     MODE_ADD};
         4'd7:    op = '{SRC_SY,   SRC_CP,      4'd3,     MODE_SET};
         4'd8:    op = '{SRC_SYSP, SRC_SR,      4'd4,     MODE_FIRST};
         4'd9:    op = '{SRC_CY,   SRC_CR,      4'd4,     MODE_ADD};
         4'd10:   op = '{SRC_SYSP, SRC_CR,      4'd5,     MODE_FIRST};
         4'd11:   op = '{SRC_CY,   SRC_SR,      4'd5,     MODE_SUB};
         4'd12:   op = '{SRC_SP,   SRC_NEG_ONE, 4'd6,     MODE_SET};
         4'd13:   op = '{SRC_CP,   SRC_SR,      4'd7,     MODE_SET};
         4'd14:   op = '{SRC_CP,   SRC_CR,      4'd8,     MODE_SET};
         default: op = '{SRC_SY,   SRC_SY,      DST_CYSP, MODE_SET};
      endcase
      return op;
   endfunction

endpackage

/* hw/rtl/ert3d_coef_gen.sv */
`include "euler_rotate_translate_3d_defines.svh"

module ert3d_coef_gen #(
   parameter int ANGLE_WIDTH = ert3d_pkg::ANGLE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [ANGLE_WIDTH-1:0] yaw_angle,
   input  logic [ANGLE_WIDTH-1:0] pitch_angle,
   input  logic [ANGLE_WIDTH-1:0] roll_angle,
   output logic                   busy,
   output ert3d_pkg::coef_type    coef [ert3d_pkg::NUM_COEFS]
);

   localparam int OPW = ert3d_pkg::OP_WIDTH;
   localparam int MW  = ert3d_pkg::MUL_WIDTH;
   localparam int CW  = ert3d_pkg::COEF_WIDTH;
   localparam int PW  = 2 * MW;
   localparam int VW  = 24;
   localparam int MAG_W = ert3d_pkg::MAG_WIDTH;

   logic [OPW-1:0] op_ff, op_in;
   logic           ph_ff, ph_in;
   logic           busy_ff, busy_in;

   logic signed [PW-1:0] mul_ff;
   logic [14:0]          t2_ff;
   logic signed [MW-1:0] in_ff;
   logic signed [MW-1:0] mid_ff;
   ert3d_pkg::coef_type  sin_ff [ert3d_pkg::NUM_SINES];
   ert3d_pkg::coef_type  cysp_ff;
   ert3d_pkg::coef_type  sysp_ff;
   logic signed [VW-1:0] acc_ff;
   ert3d_pkg::coef_type  coef_ff [ert3d_pkg::NUM_COEFS];

   logic                   is_sine;
   logic [2:0]             k;
   logic [1:0]             sub;
   ert3d_pkg::prod_op_type pop;
   logic [ANGLE_WIDTH-1:0] raw;
   logic [ANGLE_WIDTH+15:0] raw_ext;
   logic [15:0]            phase;
   logic [14:0]            u;
   logic                   neg;
   ert3d_pkg::coef_type    src_a, src_b;
   logic signed [MW-1:0]   opa, opb;
   logic signed [PW-1:0]   shr14;
   logic [MW:0]            rnd;
   logic [MAG_W-1:0]       mag;
   logic signed [VW-1:0]   m17, comb_v, sat_src;
   ert3d_pkg::coef_type    sat_v;
   logic                   last_op;

   always_comb begin
      is_sine = op_ff < OPW'(ert3d_pkg::SINE_OPS);
      k       = op_ff[4:2];
      sub     = op_ff[1:0];
      pop     = ert3d_pkg::prod_op(4'(op_ff - OPW'(ert3d_pkg::SINE_OPS)));
      last_op = op_ff == OPW'(ert3d_pkg::NUM_OPS - 1);

      case (k[2:1])
         2'd0:    raw = yaw_angle;
         2'd1:    raw = pitch_angle;
         default: raw = roll_angle;
      endcase
      // The angle is brought to a 16-bit phase; cosine is a quarter turn ahead.
      raw_ext = {raw, 16'b0};
      phase   = raw_ext[ANGLE_WIDTH+15 -: 16] + (k[0] ? 16'd16384 : 16'd0);
      u       = phase[14] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
      neg     = phase[15];

      case (pop.a_sel)
         ert3d_pkg::SRC_SY:   src_a = sin_ff[0];
         ert3d_pkg::SRC_CY:   src_a = sin_ff[1];
         ert3d_pkg::SRC_SP:   src_a = sin_ff[2];
         ert3d_pkg::SRC_CP:   src_a = sin_ff[3];
         ert3d_pkg::SRC_SR:   src_a = sin_ff[4];
         ert3d_pkg::SRC_CR:   src_a = sin_ff[5];
         ert3d_pkg::SRC_CYSP: src_a = cysp_ff;
         ert3d_pkg::SRC_SYSP: src_a = sysp_ff;
         default:             src_a = -CW'(ert3d_pkg::ONE_Q17);
      endcase
      case (pop.b_sel)
         ert3d_pkg::SRC_SY:   src_b = sin_ff[0];
         ert3d_pkg::SRC_CY:   src_b = sin_ff[1];
         ert3d_pkg::SRC_SP:   src_b = sin_ff[2];
         ert3d_pkg::SRC_CP:   src_b = sin_ff[3];
         ert3d_pkg::SRC_SR:   src_b = sin_ff[4];
         ert3d_pkg::SRC_CR:   src_b = sin_ff[5];
         ert3d_pkg::SRC_CYSP: src_b = cysp_ff;
         ert3d_pkg::SRC_SYSP: src_b = sysp_ff;
         default:             src_b = -CW'(ert3d_pkg::ONE_Q17);
      endcase

      if (is_sine) begin
         case (sub)
            2'd0: begin
               opa = MW'({1'b0, u});
               opb = MW'({1'b0, u});
            end
            2'd1: begin
               opa = ert3d_pkg::SINE_C;
               opb = MW'({1'b0, t2_ff});
            end
            2'd2: begin
               opa = in_ff;
               opb = MW'({1'b0, t2_ff});
            end
            default: begin
               opa = mid_ff;
               opb = MW'({1'b0, u});
            end
         endcase
      end else begin
         opa = MW'(src_a);
         opb = MW'(src_b);
      end

      shr14 = mul_ff >>> 14;
      rnd   = {1'b0, shr14[MW-1:0]} + (MW+1)'(4096);
      mag   = (rnd[MW:13] > (MW-12)'(ert3d_pkg::ONE_Q17)) ?
              MAG_W'(ert3d_pkg::ONE_Q17) : MAG_W'(rnd[MW:13]);

      // Rounded Q1.17 product, floor of (a*b + 2^16) / 2^17.
      m17 = VW'((mul_ff + PW'(65536)) >>> 17);
      case (pop.mode)
         ert3d_pkg::MODE_ADD: comb_v = acc_ff + m17;
         ert3d_pkg::MODE_SUB: comb_v = acc_ff - m17;
         default:             comb_v = m17;
      endcase
      sat_src = comb_v;
      if (sat_src > VW'(262143)) begin
         sat_v = CW'(262143);
      end else if (sat_src < -VW'(262144)) begin
         sat_v = -CW'(262144);
      end else begin
         sat_v = sat_src[CW-1:0];
      end

      op_in   = op_ff;
      ph_in   = ph_ff;
      busy_in = busy_ff;
      if (start) begin
         op_in   = '0;
         ph_in   = 1'b0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         ph_in = ~ph_ff;
         if (ph_ff) begin
            if (last_op) begin
               op_in   = '0;
               busy_in = 1'b0;
            end else begin
               op_in = op_ff + OPW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff   <= '0;
         ph_ff   <= 1'b0;
         busy_ff <= 1'b0;
         for (int i = 0; i < ert3d_pkg::NUM_COEFS; i++) begin
            coef_ff[i] <= (i % 4 == 0) ? CW'(ert3d_pkg::ONE_Q17) : '0;
         end
      end else begin
         op_ff   <= op_in;
         ph_ff   <= ph_in;
         busy_ff <= busy_in;
         if (busy_ff && !start && ph_ff && !is_sine) begin
            if (pop.dest < 4'(ert3d_pkg::NUM_COEFS) && pop.mode != ert3d_pkg::MODE_FIRST) begin
               coef_ff[pop.dest] <= sat_v;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && !ph_ff) begin
         mul_ff <= opa * opb;
      end
      if (busy_ff && ph_ff) begin
         if (is_sine) begin
            case (sub)
               2'd0:    t2_ff  <= shr14[14:0];
               2'd1:    in_ff  <= ert3d_pkg::SINE_B - shr14[MW-1:0];
               2'd2:    mid_ff <= ert3d_pkg::SINE_A - shr14[MW-1:0];
               default: sin_ff[k] <= neg ? -CW'(mag) : CW'(mag);
            endcase
         end else begin
            if (pop.dest == ert3d_pkg::DST_CYSP) begin
               cysp_ff <= m17[CW-1:0];
            end
            if (pop.dest == ert3d_pkg::DST_SYSP) begin
               sysp_ff <= m17[CW-1:0];
            end
            if (pop.mode == ert3d_pkg::MODE_FIRST) begin
               acc_ff <= m17;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign coef = coef_ff;

   `ERT3D_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff, "update did not start")
   `ERT3D_ASSERT_NEXT(a_finish, clock, reset, busy_ff && ph_ff && last_op && !start, !busy_ff, "update did not finish")
   `ERT3D_ASSERT_SAME(a_idle_op, clock, reset, !busy_ff, op_ff == '0 && !ph_ff, "sequencer not at rest")

endmodule

/* hw/rtl/euler_rotate_translate_3d.sv */
// Rotates each Q16.16 point by the yaw-pitch-roll matrix and adds the offset,
// saturating to the coordinate range. One point is taken per clock unless the
// output stalls or a coefficient update runs; its result is offered from the
// last of four register stages (input, nine products, row sums, offset and
// saturation). Writing any angle register starts the coefficient update, which
// runs on one shared 32x32 multiplier; req_ready stays low until it has
// finished. With all angles zero the point passes unrounded to the offset adder.
`include "euler_rotate_translate_3d_defines.svh"

module euler_rotate_translate_3d #(
   parameter int COORD_WIDTH = ert3d_pkg::COORD_WIDTH,
   parameter int ANGLE_WIDTH = ert3d_pkg::ANGLE_WIDTH,
   localparam int CSR_DATA_WIDTH = (COORD_WIDTH > 32) ? 64 : 32,
   localparam int STRIDE_SHIFT   = (CSR_DATA_WIDTH == 64) ? 3 : 2,
   localparam int ADDR_WIDTH     = ert3d_pkg::REG_IDX_WIDTH + STRIDE_SHIFT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_moved_x,
   output logic signed [COORD_WIDTH-1:0] rsp_moved_y,
   output logic signed [COORD_WIDTH-1:0] rsp_moved_z,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ADDR_WIDTH-1:0]         csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                          csr_pready
);

   localparam int CW = COORD_WIDTH;
   localparam int KW = ert3d_pkg::COEF_WIDTH;
   localparam int PW = CW + KW;
   localparam int SW = PW + 2;
   localparam int RW = CW + 4;
   localparam int OW = RW + 1;

   // Configuration registers.
   logic [ANGLE_WIDTH-1:0] yaw_ff, pitch_ff, roll_ff;
   logic signed [CW-1:0]   off_ff [3];
   logic [ert3d_pkg::REG_IDX_WIDTH-1:0] reg_idx;
   logic csr_wr, coef_start, coef_busy, all_zero;
   ert3d_pkg::coef_type coef [ert3d_pkg::NUM_COEFS];

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[ADDR_WIDTH-1:STRIDE_SHIFT];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign coef_start = csr_wr && (reg_idx == ert3d_pkg::REG_YAW ||
                                  reg_idx == ert3d_pkg::REG_PITCH ||
                                  reg_idx == ert3d_pkg::REG_ROLL);
   assign all_zero   = yaw_ff == '0 && pitch_ff == '0 && roll_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff   <= '0;
         pitch_ff <= '0;
         roll_ff  <= '0;
         for (int i = 0; i < 3; i++) begin
            off_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         unique case (reg_idx)
            ert3d_pkg::REG_YAW:      yaw_ff    <= csr_pwdata[ANGLE_WIDTH-1:0];
            ert3d_pkg::REG_PITCH:    pitch_ff  <= csr_pwdata[ANGLE_WIDTH-1:0];
            ert3d_pkg::REG_ROLL:     roll_ff   <= csr_pwdata[ANGLE_WIDTH-1:0];
            ert3d_pkg::REG_OFFSET_X: off_ff[0] <= csr_pwdata[CW-1:0];
            ert3d_pkg::REG_OFFSET_Y: off_ff[1] <= csr_pwdata[CW-1:0];
            ert3d_pkg::REG_OFFSET_Z: off_ff[2] <= csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         ert3d_pkg::REG_YAW:      csr_prdata = CSR_DATA_WIDTH'(yaw_ff);
         ert3d_pkg::REG_PITCH:    csr_prdata = CSR_DATA_WIDTH'(pitch_ff);
         ert3d_pkg::REG_ROLL:     csr_prdata = CSR_DATA_WIDTH'(roll_ff);
         ert3d_pkg::REG_OFFSET_X: csr_prdata = CSR_DATA_WIDTH'(unsigned'(off_ff[0]));
         ert3d_pkg::REG_OFFSET_Y: csr_prdata = CSR_DATA_WIDTH'(unsigned'(off_ff[1]));
         ert3d_pkg::REG_OFFSET_Z: csr_prdata = CSR_DATA_WIDTH'(unsigned'(off_ff[2]));
         default:                 csr_prdata = '0;
      endcase
   end

   ert3d_coef_gen #(
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_coef_gen (
      .clock       (clock),
      .reset       (reset),
      .start       (coef_start),
      .yaw_angle   (yaw_ff),
      .pitch_angle (pitch_ff),
      .roll_angle  (roll_ff),
      .busy        (coef_busy),
      .coef        (coef)
   );

   // Pipeline stages; each advances when its successor is empty or moving.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic en1, en2, en3, en4;
   logic signed [CW-1:0] pt1_ff [3];
   logic signed [CW-1:0] pt2_ff [3];
   logic                 byp1_ff, byp2_ff;
   logic signed [PW-1:0] prod_ff [ert3d_pkg::NUM_COEFS];
   logic signed [RW-1:0] rot3_ff [3];
   logic signed [CW-1:0] out4_ff [3];
   logic signed [SW-1:0] row_sum [3];
   logic signed [RW-1:0] rot_in [3];
   logic signed [OW-1:0] moved [3];
   logic signed [CW-1:0] out_in [3];

   assign en4 = !s4_valid_ff || rsp_ready;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_ready = en1 && !coef_busy;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_sum[r] = SW'(prod_ff[3*r]) + SW'(prod_ff[3*r+1]) + SW'(prod_ff[3*r+2])
                      + SW'(65536);
         rot_in[r]  = byp2_ff ? RW'(pt2_ff[r]) : RW'(row_sum[r] >>> 17);
         moved[r]   = OW'(rot3_ff[r]) + OW'(off_ff[r]);
         // Out of range when the bits above the result's sign disagree.
         if (moved[r][OW-1:CW-1] != {(OW-CW+1){moved[r][OW-1]}}) begin
            out_in[r] = moved[r][OW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         end else begin
            out_in[r] = moved[r][CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_valid && req_ready;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         pt1_ff[0] <= req_point_x;
         pt1_ff[1] <= req_point_y;
         pt1_ff[2] <= req_point_z;
         byp1_ff   <= all_zero;
      end
      if (en2) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[3*r+c] <= PW'(coef[3*r+c]) * PW'(pt1_ff[c]);
            end
            pt2_ff[r] <= pt1_ff[r];
         end
         byp2_ff <= byp1_ff;
      end
      if (en3) begin
         for (int r = 0; r < 3; r++) begin
            rot3_ff[r] <= rot_in[r];
         end
      end
      if (en4) begin
         for (int r = 0; r < 3; r++) begin
            out4_ff[r] <= out_in[r];
         end
      end
   end

   assign rsp_valid   = s4_valid_ff;
   assign rsp_moved_x = out4_ff[0];
   assign rsp_moved_y = out4_ff[1];
   assign rsp_moved_z = out4_ff[2];

   `ERT3D_ASSERT_SAME(a_no_transfer_busy, clock, reset, req_valid && req_ready, !coef_busy, "point taken during coefficient update")
   `ERT3D_ASSERT_NEXT(a_stage1_load, clock, reset, req_valid && req_ready, s1_valid_ff, "transferred point lost at stage one")
   `ERT3D_ASSERT_NEXT(a_stage3_hold, clock, reset, s3_valid_ff && !en3, s3_valid_ff && $stable(rot3_ff[0]), "stalled stage three changed")

endmodule
